[hw/rtl/pcxd_pkg.sv]
package pcxd_pkg;

  localparam int unsigned HEADER_BYTES    = 128;
  localparam int unsigned PALETTE_BYTES   = 768;
  localparam int unsigned PALETTE_ENTRIES = PALETTE_BYTES / 3;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ADDR_W    = 10;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned RUN_W     = 6;
  localparam int unsigned IDX_W     = $clog2(PALETTE_ENTRIES);
  localparam int unsigned HDR_CNT_W = $clog2(HEADER_BYTES);

  // addr / 3 as (addr * 683) >> 11, exact below 2048
  localparam int unsigned DIV3_MUL   = 683;
  localparam int unsigned DIV3_SHIFT = 11;

  localparam logic [BYTE_W-1:0] RUN_MARK     = 8'hC0;
  localparam logic [BYTE_W-1:0] HDR_MANUF_ID = 8'h0A;
  localparam logic [BYTE_W-1:0] HDR_VERSION  = 8'd5;
  localparam logic [BYTE_W-1:0] HDR_ENCODING = 8'd1;
  localparam logic [BYTE_W-1:0] HDR_BPP      = 8'd8;

  localparam logic [HDR_CNT_W-1:0] OFS_MANUF    = HDR_CNT_W'(0);
  localparam logic [HDR_CNT_W-1:0] OFS_VERSION  = HDR_CNT_W'(1);
  localparam logic [HDR_CNT_W-1:0] OFS_ENCODING = HDR_CNT_W'(2);
  localparam logic [HDR_CNT_W-1:0] OFS_BPP      = HDR_CNT_W'(3);
  localparam logic [HDR_CNT_W-1:0] OFS_XMAX_LO  = HDR_CNT_W'(8);
  localparam logic [HDR_CNT_W-1:0] OFS_XMAX_HI  = HDR_CNT_W'(9);
  localparam logic [HDR_CNT_W-1:0] OFS_YMAX_LO  = HDR_CNT_W'(10);
  localparam logic [HDR_CNT_W-1:0] OFS_YMAX_HI  = HDR_CNT_W'(11);
  localparam logic [HDR_CNT_W-1:0] OFS_LAST     = HDR_CNT_W'(HEADER_BYTES - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_PALETTE = 2'd1,
    CMD_FILE    = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_HDR_OK  = 2'd1,
    KIND_HDR_BAD = 2'd2
  } kind_e;

  typedef struct packed {
    logic accept;
    logic load_status;
    logic load_pixel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic want_status;
    logic want_pixels;
    logic out_free;
    logic pixel_last;
  } dp_stat_t;

endpackage

[hw/rtl/pcxd_in_if.sv]
interface pcxd_in_if;
  import pcxd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] byte_value;
  logic [ADDR_W-1:0] palette_addr;

  modport source (output valid, cmd, byte_value, palette_addr, input ready);
  modport sink   (input valid, cmd, byte_value, palette_addr, output ready);
endinterface

[hw/rtl/pcxd_out_if.sv]
interface pcxd_out_if;
  import pcxd_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [BYTE_W-1:0]  color_index;
  logic [BYTE_W-1:0]  red;
  logic [BYTE_W-1:0]  green;
  logic [BYTE_W-1:0]  blue;
  logic               last;
  logic               image_done;

  modport source (output valid, kind, column, row, color_index, red, green, blue, last,
                  image_done, input ready);
  modport sink   (input valid, kind, column, row, color_index, red, green, blue, last,
                  image_done, output ready);
endinterface

[hw/rtl/pcx_rle_palette_decoder.sv]
// 8-bit PCX run-length decoder with a 256-colour RGB palette.
// in_ch words carry a command: start (clears the decoder, keeps the palette),
// palette byte write (entry*3 + colour lane), or file byte. The first 128
// file bytes are the header; its last byte yields one status word on out_ch
// (accepted or rejected). Later bytes are literal pixels or run markers
// whose low six bits repeat the next byte, clipped at row end.
// Each pixel word carries column, row, index and the palette RGB; last marks
// the final word caused by one input word, image_done the final pixel.
// Timing: one input word is worked on at a time. A header-end word passes
// through S_STATUS, which loads its status word into the output register. A
// pixel word passes through S_LOOKUP for the palette RAM read, then S_EMIT
// gives one pixel per cycle while the output register is free. The output
// register holds the next result while the receiver stalls; decoding pauses
// until it is taken.
// Reset clears the decoder to the header phase; palette contents are
// undefined until written.
module pcx_rle_palette_decoder (
  input logic        clk,
  input logic        rst_n,
  pcxd_in_if.sink    in_ch,
  pcxd_out_if.source out_ch
);
  import pcxd_pkg::*;

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  pcxd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  pcxd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_cmd          (in_ch.cmd),
    .in_byte_value   (in_ch.byte_value),
    .in_palette_addr (in_ch.palette_addr),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_column      (out_ch.column),
    .out_row         (out_ch.row),
    .out_color_index (out_ch.color_index),
    .out_red         (out_ch.red),
    .out_green       (out_ch.green),
    .out_blue        (out_ch.blue),
    .out_last        (out_ch.last),
    .out_image_done  (out_ch.image_done)
  );

endmodule

[hw/rtl/pcxd_dp.sv]
module pcxd_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pcxd_pkg::ctrl_cmd_t        ctrl,
  output pcxd_pkg::dp_stat_t         stat,
  input  logic [pcxd_pkg::CMD_W-1:0]   in_cmd,
  input  logic [pcxd_pkg::BYTE_W-1:0]  in_byte_value,
  input  logic [pcxd_pkg::ADDR_W-1:0]  in_palette_addr,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pcxd_pkg::KIND_W-1:0]  out_kind,
  output logic [pcxd_pkg::COORD_W-1:0] out_column,
  output logic [pcxd_pkg::COORD_W-1:0] out_row,
  output logic [pcxd_pkg::BYTE_W-1:0]  out_color_index,
  output logic [pcxd_pkg::BYTE_W-1:0]  out_red,
  output logic [pcxd_pkg::BYTE_W-1:0]  out_green,
  output logic [pcxd_pkg::BYTE_W-1:0]  out_blue,
  output logic                       out_last,
  output logic                       out_image_done
);
  import pcxd_pkg::*;

  localparam int unsigned PROD_W = ADDR_W + DIV3_SHIFT;
  localparam logic [1:0] LANE_RED   = 2'd0;
  localparam logic [1:0] LANE_GREEN = 2'd1;
  localparam logic [1:0] LANE_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_REJECT = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  phase_e               phase_r;
  logic [HDR_CNT_W-1:0] hdr_cnt_r;
  logic                 hdr_bad_r;
  logic [COORD_W-1:0]   last_col_r;
  logic [COORD_W-1:0]   last_row_r;
  logic [COORD_W-1:0]   col_r;
  logic [COORD_W-1:0]   row_r;
  logic                 run_pend_r;
  logic [RUN_W-1:0]     run_len_r;
  logic [RUN_W-1:0]     rem_r;
  logic [IDX_W-1:0]     idx_r;

  logic [BYTE_W-1:0] red_mem   [PALETTE_ENTRIES];
  logic [BYTE_W-1:0] green_mem [PALETTE_ENTRIES];
  logic [BYTE_W-1:0] blue_mem  [PALETTE_ENTRIES];
  logic [BYTE_W-1:0] red_q_r;
  logic [BYTE_W-1:0] green_q_r;
  logic [BYTE_W-1:0] blue_q_r;

  logic               out_valid_r;
  kind_e              kind_o_r;
  logic [COORD_W-1:0] col_o_r;
  logic [COORD_W-1:0] row_o_r;
  logic [BYTE_W-1:0]  cidx_o_r;
  logic [BYTE_W-1:0]  red_o_r;
  logic [BYTE_W-1:0]  green_o_r;
  logic [BYTE_W-1:0]  blue_o_r;
  logic               last_o_r;
  logic               done_o_r;

  logic [PROD_W-1:0] addr_prod;
  logic [IDX_W-1:0]  pal_entry;
  logic [ADDR_W-1:0] entry_x3;
  logic [1:0]        pal_lane;
  logic              pal_we;
  logic              is_file;
  logic              is_mark;
  logic              hdr_last;
  logic              col_end;
  logic              row_end;

  // palette byte address -> entry and colour lane
  assign addr_prod = PROD_W'(in_palette_addr) * PROD_W'(DIV3_MUL);
  assign pal_entry = addr_prod[DIV3_SHIFT +: IDX_W];
  assign entry_x3  = ADDR_W'({pal_entry, 1'b0}) + ADDR_W'(pal_entry);
  assign pal_lane  = 2'(in_palette_addr - entry_x3);
  assign pal_we    = ctrl.accept && (in_cmd == CMD_PALETTE)
                     && (in_palette_addr < ADDR_W'(PALETTE_BYTES));

  assign is_file  = (in_cmd == CMD_FILE);
  assign is_mark  = (in_byte_value & RUN_MARK) == RUN_MARK;
  assign hdr_last = (hdr_cnt_r == OFS_LAST);
  assign col_end  = (col_r == last_col_r);
  assign row_end  = (row_r == last_row_r);

  assign stat.want_status = is_file && (phase_r == PH_HEADER) && hdr_last;
  assign stat.want_pixels = is_file && (phase_r == PH_DATA)
                            && (run_pend_r ? (run_len_r != '0) : !is_mark);
  assign stat.out_free    = !out_valid_r || out_ready;
  // runs are clipped at row end
  assign stat.pixel_last  = (rem_r == RUN_W'(1)) || col_end;

  always_ff @(posedge clk) begin
    if (pal_we && (pal_lane == LANE_RED)) begin
      red_mem[pal_entry] <= in_byte_value;
    end
    if (pal_we && (pal_lane == LANE_GREEN)) begin
      green_mem[pal_entry] <= in_byte_value;
    end
    if (pal_we && (pal_lane == LANE_BLUE)) begin
      blue_mem[pal_entry] <= in_byte_value;
    end
    red_q_r   <= red_mem[idx_r];
    green_q_r <= green_mem[idx_r];
    blue_q_r  <= blue_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hdr_cnt_r   <= '0;
      hdr_bad_r   <= 1'b0;
      last_col_r  <= '0;
      last_row_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      run_pend_r  <= 1'b0;
      run_len_r   <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.load_status || ctrl.load_pixel) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (ctrl.accept) begin
        case (in_cmd)
          CMD_START: begin
            phase_r    <= PH_HEADER;
            hdr_cnt_r  <= '0;
            hdr_bad_r  <= 1'b0;
            last_col_r <= '0;
            last_row_r <= '0;
            col_r      <= '0;
            row_r      <= '0;
            run_pend_r <= 1'b0;
            run_len_r  <= '0;
          end
          CMD_FILE: begin
            case (phase_r)
              PH_HEADER: begin
                case (hdr_cnt_r)
                  OFS_MANUF:    if (in_byte_value != HDR_MANUF_ID) hdr_bad_r <= 1'b1;
                  OFS_VERSION:  if (in_byte_value != HDR_VERSION)  hdr_bad_r <= 1'b1;
                  OFS_ENCODING: if (in_byte_value != HDR_ENCODING) hdr_bad_r <= 1'b1;
                  OFS_BPP:      if (in_byte_value != HDR_BPP)      hdr_bad_r <= 1'b1;
                  OFS_XMAX_LO:  last_col_r[7:0]  <= in_byte_value;
                  OFS_XMAX_HI:  last_col_r[15:8] <= in_byte_value;
                  OFS_YMAX_LO:  last_row_r[7:0]  <= in_byte_value;
                  OFS_YMAX_HI:  last_row_r[15:8] <= in_byte_value;
                  default: ;
                endcase
                if (hdr_last) begin
                  hdr_cnt_r <= '0;
                  phase_r   <= hdr_bad_r ? PH_REJECT : PH_DATA;
                end else begin
                  hdr_cnt_r <= hdr_cnt_r + HDR_CNT_W'(1);
                end
              end
              PH_DATA: begin
                if (run_pend_r) begin
                  run_pend_r <= 1'b0;
                  rem_r      <= run_len_r;
                  run_len_r  <= '0;
                end else if (is_mark) begin
                  run_pend_r <= 1'b1;
                  run_len_r  <= in_byte_value[RUN_W-1:0];
                end else begin
                  rem_r <= RUN_W'(1);
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end

      if (ctrl.load_pixel) begin
        rem_r <= rem_r - RUN_W'(1);
        if (col_end) begin
          col_r <= '0;
          if (row_end) begin
            phase_r <= PH_DONE;
          end else begin
            row_r <= row_r + COORD_W'(1);
          end
        end else begin
          col_r <= col_r + COORD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept && stat.want_pixels) begin
      idx_r <= in_byte_value;
    end
    if (ctrl.load_status) begin
      kind_o_r  <= hdr_bad_r ? KIND_HDR_BAD : KIND_HDR_OK;
      col_o_r   <= '0;
      row_o_r   <= '0;
      cidx_o_r  <= '0;
      red_o_r   <= '0;
      green_o_r <= '0;
      blue_o_r  <= '0;
      last_o_r  <= 1'b1;
      done_o_r  <= 1'b0;
    end else if (ctrl.load_pixel) begin
      kind_o_r  <= KIND_PIXEL;
      col_o_r   <= col_r;
      row_o_r   <= row_r;
      cidx_o_r  <= idx_r;
      red_o_r   <= red_q_r;
      green_o_r <= green_q_r;
      blue_o_r  <= blue_q_r;
      last_o_r  <= stat.pixel_last;
      done_o_r  <= col_end && row_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_o_r;
  assign out_column      = col_o_r;
  assign out_row         = row_o_r;
  assign out_color_index = cidx_o_r;
  assign out_red         = red_o_r;
  assign out_green       = green_o_r;
  assign out_blue        = blue_o_r;
  assign out_last        = last_o_r;
  assign out_image_done  = done_o_r;

endmodule

[hw/rtl/pcxd_ctrl.sv]
module pcxd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcxd_pkg::dp_stat_t  stat,
  output pcxd_pkg::ctrl_cmd_t ctrl
);
  import pcxd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_STATUS = 2'd1,
    S_LOOKUP = 2'd2,
    S_EMIT   = 2'd3
  } state_e;

  state_e state_r;
  state_e state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt        = state_r;
    ctrl.accept      = 1'b0;
    ctrl.load_status = 1'b0;
    ctrl.load_pixel  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ctrl.accept = in_valid;
        if (in_valid && stat.want_status) begin
          state_nxt = S_STATUS;
        end else if (in_valid && stat.want_pixels) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_STATUS: begin
        if (stat.out_free) begin
          ctrl.load_status = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      // palette read of the pixel index
      S_LOOKUP: state_nxt = S_EMIT;
      S_EMIT: begin
        if (stat.out_free) begin
          ctrl.load_pixel = 1'b1;
          if (stat.pixel_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
